/* rtl/rdiv_pkg.sv */
// ----------------------------------------------------------------------------
// rdiv_pkg: shared constants of the restoring divider
// Sets how many long-division steps each pipeline stage retires.
// ----------------------------------------------------------------------------
package rdiv_pkg;

  // Quotient bits resolved per register stage (dependent trial subtracts).
  localparam int unsigned STEPS_PER_STAGE = 4;

endpackage : rdiv_pkg

/* rtl/rdiv_stage.sv */
// ----------------------------------------------------------------------------
// rdiv_stage: one pipeline stage of the restoring divider
// Runs STEPS_PER_STAGE shift / trial-subtract steps and registers the result.
// ----------------------------------------------------------------------------
module rdiv_stage
  import rdiv_pkg::*;
#(
  parameter int unsigned WORD_WIDTH    = 64,
  parameter int unsigned DIVISOR_WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [DIVISOR_WIDTH-1:0] in_rem,
  input  logic [WORD_WIDTH-1:0]    in_word,
  input  logic [DIVISOR_WIDTH-1:0] in_divisor,
  input  logic                     in_dbz,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [DIVISOR_WIDTH-1:0] out_rem,
  output logic [WORD_WIDTH-1:0]    out_word,
  output logic [DIVISOR_WIDTH-1:0] out_divisor,
  output logic                     out_dbz
);

  logic                     valid_r;
  logic                     valid_nxt;
  logic [DIVISOR_WIDTH-1:0] rem_r;
  logic [DIVISOR_WIDTH-1:0] rem_nxt;
  logic [WORD_WIDTH-1:0]    word_r;
  logic [WORD_WIDTH-1:0]    word_nxt;
  logic [DIVISOR_WIDTH-1:0] divisor_r;
  logic                     dbz_r;

  // Take a new transaction when empty or when the held one moves on.
  assign in_ready  = !valid_r || out_ready;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  // Word holds unconsumed dividend bits on top, quotient bits shift in below.
  always_comb begin
    logic [DIVISOR_WIDTH-1:0] rem_v;
    logic [WORD_WIDTH-1:0]    word_v;
    logic [DIVISOR_WIDTH:0]   trial_v;
    rem_v   = in_rem;
    word_v  = in_word;
    trial_v = '0;
    for (int s = 0; s < STEPS_PER_STAGE; s++) begin
      trial_v = {rem_v, word_v[WORD_WIDTH-1]};
      if (trial_v >= {1'b0, in_divisor}) begin
        trial_v = trial_v - {1'b0, in_divisor};
        word_v  = {word_v[WORD_WIDTH-2:0], 1'b1};
      end else begin
        word_v  = {word_v[WORD_WIDTH-2:0], 1'b0};
      end
      rem_v = trial_v[DIVISOR_WIDTH-1:0];
    end
    rem_nxt  = rem_v;
    word_nxt = word_v;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      rem_r     <= rem_nxt;
      word_r    <= word_nxt;
      divisor_r <= in_divisor;
      dbz_r     <= in_dbz;
    end
  end

  assign out_valid   = valid_r;
  assign out_rem     = rem_r;
  assign out_word    = word_r;
  assign out_divisor = divisor_r;
  assign out_dbz     = dbz_r;

endmodule : rdiv_stage

/* rtl/rdiv_skid.sv */
// ----------------------------------------------------------------------------
// rdiv_skid: two-entry output buffer
// Registers the result and breaks the ready path to the pipeline.
// ----------------------------------------------------------------------------
module rdiv_skid #(
  parameter int unsigned DATA_WIDTH = 65
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [DATA_WIDTH-1:0] in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DATA_WIDTH-1:0] out_data
);

  logic                  main_valid_r;
  logic                  main_valid_nxt;
  logic                  skid_valid_r;
  logic                  skid_valid_nxt;
  logic [DATA_WIDTH-1:0] main_r;
  logic [DATA_WIDTH-1:0] main_nxt;
  logic [DATA_WIDTH-1:0] skid_r;
  logic [DATA_WIDTH-1:0] skid_nxt;
  logic                  pop;
  logic                  push;

  assign in_ready  = !skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;
  assign pop       = main_valid_r && out_ready;
  assign push      = in_valid && in_ready;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (pop) begin
      if (skid_valid_r) begin
        main_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end else begin
        main_valid_nxt = 1'b0;
      end
    end
    if (push) begin
      if (!main_valid_nxt) begin
        main_nxt       = in_data;
        main_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = in_data;
        skid_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule : rdiv_skid

/* rtl/restoring_divider_64_by_8.sv */
// Path: a transaction passes through the chain of stage registers, each retiring 4
//   steps, then through the main register of the output buffer.
// Throughput: one transaction per cycle; a stall on the result side backs up
//   the stage chain without losing or repeating anything.
// Reset: synchronous, active low; clears all valid bits, payload is not reset.
// ----------------------------------------------------------------------------
// restoring_divider_64_by_8: pipelined restoring long division
// Unsigned dividend over unsigned divisor, full-width quotient plus a
// divide-by-zero flag. Remainder is dropped.
// ----------------------------------------------------------------------------
module restoring_divider_64_by_8
  import rdiv_pkg::*;
#(
  parameter int unsigned DIVIDEND_WIDTH = 64,
  parameter int unsigned DIVISOR_WIDTH  = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [DIVIDEND_WIDTH-1:0] in_dividend,
  input  logic [DIVISOR_WIDTH-1:0]  in_divisor,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [DIVIDEND_WIDTH-1:0] out_quotient,
  output logic                      out_divide_by_zero
);

  // Stage count and the padded word that the stages shift through.
  localparam int unsigned NUM_STAGES =
    (DIVIDEND_WIDTH + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int unsigned WORD_WIDTH = NUM_STAGES * STEPS_PER_STAGE;
  localparam int unsigned RES_WIDTH  = DIVIDEND_WIDTH + 1;

  // Chain signals: index k is the input side of stage k, NUM_STAGES the tail.
  logic                     valid_w   [0:NUM_STAGES];
  logic                     ready_w   [0:NUM_STAGES];
  logic [DIVISOR_WIDTH-1:0] rem_w     [0:NUM_STAGES-1];
  logic [WORD_WIDTH-1:0]    word_w    [0:NUM_STAGES];
  logic [DIVISOR_WIDTH-1:0] divisor_w [0:NUM_STAGES];
  logic                     dbz_w     [0:NUM_STAGES];

  logic [RES_WIDTH-1:0]     res_in;
  logic [RES_WIDTH-1:0]     res_out;

  // Head of the chain: zero remainder, dividend zero-extended on top so the
  // padding bits only feed quotient bits that get dropped at the tail.
  assign valid_w[0]   = in_valid;
  assign in_ready     = ready_w[0];
  assign rem_w[0]     = '0;
  assign word_w[0]    = WORD_WIDTH'(in_dividend);
  assign divisor_w[0] = in_divisor;
  // A zero divisor passes every trial compare, so the quotient comes out
  // all ones on its own; only the flag needs to be carried along.
  assign dbz_w[0]     = (in_divisor == '0);

  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
    if (k == NUM_STAGES - 1) begin : g_last
      // Final remainder is not reported; leave it open.
      rdiv_stage #(
        .WORD_WIDTH   (WORD_WIDTH),
        .DIVISOR_WIDTH(DIVISOR_WIDTH)
      ) u_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (valid_w[k]),
        .in_ready   (ready_w[k]),
        .in_rem     (rem_w[k]),
        .in_word    (word_w[k]),
        .in_divisor (divisor_w[k]),
        .in_dbz     (dbz_w[k]),
        .out_valid  (valid_w[k+1]),
        .out_ready  (ready_w[k+1]),
        .out_rem    (),
        .out_word   (word_w[k+1]),
        .out_divisor(divisor_w[k+1]),
        .out_dbz    (dbz_w[k+1])
      );
    end else begin : g_mid
      rdiv_stage #(
        .WORD_WIDTH   (WORD_WIDTH),
        .DIVISOR_WIDTH(DIVISOR_WIDTH)
      ) u_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (valid_w[k]),
        .in_ready   (ready_w[k]),
        .in_rem     (rem_w[k]),
        .in_word    (word_w[k]),
        .in_divisor (divisor_w[k]),
        .in_dbz     (dbz_w[k]),
        .out_valid  (valid_w[k+1]),
        .out_ready  (ready_w[k+1]),
        .out_rem    (rem_w[k+1]),
        .out_word   (word_w[k+1]),
        .out_divisor(divisor_w[k+1]),
        .out_dbz    (dbz_w[k+1])
      );
    end
  end

  // Tail: keep the low DIVIDEND_WIDTH quotient bits plus the flag. The
  // divisor copy at the tail also gates the flag with a zero check.
  assign res_in = {dbz_w[NUM_STAGES] & (divisor_w[NUM_STAGES] == '0),
                   word_w[NUM_STAGES][DIVIDEND_WIDTH-1:0]};

  // Output buffer: ready toward the stages comes from a register.
  rdiv_skid #(
    .DATA_WIDTH(RES_WIDTH)
  ) u_skid (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (valid_w[NUM_STAGES]),
    .in_ready (ready_w[NUM_STAGES]),
    .in_data  (res_in),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (res_out)
  );

  assign out_quotient       = res_out[DIVIDEND_WIDTH-1:0];
  assign out_divide_by_zero = res_out[DIVIDEND_WIDTH];

endmodule : restoring_divider_64_by_8

/* rtl/rdiv_checker.sv */
// ----------------------------------------------------------------------------
// rdiv_checker: port-level checks for the restoring divider
// Tracks transactions in flight and checks result behavior over time.
// ----------------------------------------------------------------------------
module rdiv_checker
  import rdiv_pkg::*;
#(
  parameter int unsigned DIVIDEND_WIDTH = 64,
  parameter int unsigned DIVISOR_WIDTH  = 8
) (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic [DIVIDEND_WIDTH-1:0] in_dividend,
  input logic [DIVISOR_WIDTH-1:0]  in_divisor,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [DIVIDEND_WIDTH-1:0] out_quotient,
  input logic                      out_divide_by_zero
);

  // Stages plus two output buffer entries.
  localparam int unsigned CAPACITY =
    (DIVIDEND_WIDTH + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE + 2;
  localparam int unsigned CNT_WIDTH = $clog2(CAPACITY + 1) + 1;

  logic [CNT_WIDTH-1:0] count_r;
  logic [CNT_WIDTH-1:0] count_nxt;
  logic                 in_fire;
  logic                 out_fire;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  always_comb begin
    count_nxt = count_r;
    if (in_fire && !out_fire) begin
      count_nxt = count_r + CNT_WIDTH'(1);
    end else if (out_fire && !in_fire) begin
      count_nxt = count_r - CNT_WIDTH'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // A held result does not change while stalled.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_quotient) &&
                                $stable(out_divide_by_zero))
    else $error("result changed while stalled");

  // No result without a transaction in flight.
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> count_r != '0)
    else $error("result without a pending transaction");

  // In-flight count never exceeds the pipeline's storage.
  a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_WIDTH'(CAPACITY))
    else $error("more transactions in flight than storage");

  // Divide by zero always reports an all-ones quotient.
  a_dbz_ones: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_divide_by_zero |-> out_quotient == '1)
    else $error("divide by zero without all-ones quotient");

  // Reset empties the result side.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Inputs are watched for completeness of the port view only.
  logic unused_in;
  assign unused_in = ^{in_dividend, in_divisor};

endmodule : rdiv_checker

bind restoring_divider_64_by_8 rdiv_checker #(
  .DIVIDEND_WIDTH(DIVIDEND_WIDTH),
  .DIVISOR_WIDTH (DIVISOR_WIDTH)
) u_rdiv_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .in_dividend       (in_dividend),
  .in_divisor        (in_divisor),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_quotient      (out_quotient),
  .out_divide_by_zero(out_divide_by_zero)
);
